@@ src/fdc_cmd_pkg.sv @@
// ----------------------------------------------------------------------------
// fdc_cmd_pkg - shared types and constants of the floppy controller command phase
// phase encoding, bus access kinds, command opcodes, status bits, length table
// ----------------------------------------------------------------------------
package fdc_cmd_pkg;

    // controller phase
    typedef enum logic [1:0] {
        PHASE_IDLE    = 2'd0,
        PHASE_COMMAND = 2'd1,
        PHASE_RESULT  = 2'd2
    } phase_t;

    // bus access kind
    localparam logic [1:0] MODE_STATUS_RD = 2'd0;
    localparam logic [1:0] MODE_DATA_WR   = 2'd1;
    localparam logic [1:0] MODE_DATA_RD   = 2'd2;
    localparam logic [1:0] MODE_UNUSED    = 2'd3;

    // command opcodes (low nibble of the first byte)
    localparam logic [3:0] OP_SPECIFY     = 4'h3;
    localparam logic [3:0] OP_WRITE_DATA  = 4'h5;
    localparam logic [3:0] OP_READ_DATA   = 4'h6;
    localparam logic [3:0] OP_RECALIBRATE = 4'h7;
    localparam logic [3:0] OP_SENSE_INT   = 4'h8;
    localparam logic [3:0] OP_SEEK        = 4'hf;

    // status and result byte constants
    localparam logic [7:0] ST_READY       = 8'h80;
    localparam logic [7:0] ST_BUSY        = 8'h10;
    localparam logic [7:0] ST_DIO         = 8'h40;
    localparam logic [7:0] ST0_SEEK_END   = 8'h20;
    localparam logic [7:0] ST0_ABNORMAL   = 8'ha0;
    localparam logic [7:0] NO_CYLINDER    = 8'hff;
    localparam logic [7:0] INVALID_CMD    = 8'h80;

    localparam int DRIVE_COUNT = 4;

    // command length in bytes, by opcode
    function automatic logic [3:0] cmd_length(input logic [3:0] op);
        logic [3:0] len;
        unique case (op)
            4'h0: len = 4'd1;
            4'h1: len = 4'd9;
            4'h2: len = 4'd9;
            4'h3: len = 4'd3;
            4'h4: len = 4'd2;
            4'h5: len = 4'd9;
            4'h6: len = 4'd9;
            4'h7: len = 4'd2;
            4'h8: len = 4'd1;
            4'h9: len = 4'd9;
            4'ha: len = 4'd2;
            4'hb: len = 4'd1;
            4'hc: len = 4'd9;
            4'hd: len = 4'd9;
            4'he: len = 4'd1;
            4'hf: len = 4'd3;
            default: len = 4'd1;
        endcase
        return len;
    endfunction

endpackage

@@ src/floppy_controller_command_phase.sv @@
// ----------------------------------------------------------------------------
// floppy_controller_command_phase - command/result phase of a floppy controller
// one bus access per input beat, one read byte per output beat; drive cylinders
// live in a small synchronous memory with valid bits
// ----------------------------------------------------------------------------
// output: the read byte is registered and appears on m_tdata in the cycle after its input beat
// throughput: one access per cycle while the receiver takes each beat; a held beat stalls input
// a sense interrupt fetches cylinder 0 from the memory through a registered read;
// the result byte it feeds is popped two beats later at the earliest, so no stall
// reset (aresetn low, synchronous): phase idle, counters zero, all cylinders
// read as zero through cleared valid bits, output channel empty
module floppy_controller_command_phase (
    input  logic        aclk,
    input  logic        aresetn,
    // access channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [1:0] mode, [9:2] write_byte, [15:10] zero
    // read byte channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [7:0] read_byte
);

    // input fields
    logic [1:0] mode;
    logic [7:0] wr_byte;
    logic       accept;

    assign mode    = s_tdata[1:0];
    assign wr_byte = s_tdata[9:2];

    // control state
    fdc_cmd_pkg::phase_t phase_reg, phase_next;
    logic [3:0] bw_reg, bw_next;            // command bytes written so far
    logic [3:0] cmd_op_reg, cmd_op_next;    // opcode nibble of the first byte
    logic [1:0] cmd_drv_reg, cmd_drv_next;  // drive bits of the second byte
    logic [1:0] drive_reg, drive_next;      // selected drive
    logic [1:0] rlen_reg, rlen_next;        // result length
    logic [1:0] rpos_reg, rpos_next;        // result read position
    logic [7:0] reply0_reg, reply0_next;
    logic [7:0] reply1_reg, reply1_next;

    // cylinder memory, one entry per drive
    logic [7:0] cyl_mem [fdc_cmd_pkg::DRIVE_COUNT];
    logic [fdc_cmd_pkg::DRIVE_COUNT-1:0] cyl_valid_reg;
    logic       mem_we;
    logic [1:0] mem_waddr;
    logic [7:0] mem_wdata;
    logic       mem_re;
    logic [7:0] cyl_rd_reg;                 // registered read of cylinder 0
    logic       cyl_rd_ok_reg;              // entry had been written
    logic       sense_pend_reg, sense_pend_next;

    // output register
    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic [7:0] rd_byte;

    // command decode helpers
    logic [3:0] op_cur;
    logic [3:0] bw_inc;
    logic       cmd_done;
    logic [1:0] drv_cur;
    logic [2:0] drv_ext;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // the first byte's opcode is the incoming byte when nothing is stored yet
    assign op_cur   = (bw_reg == 4'd0) ? wr_byte[3:0] : cmd_op_reg;
    assign bw_inc   = bw_reg + 4'd1;
    assign cmd_done = fdc_cmd_pkg::cmd_length(op_cur) <= bw_inc;
    // drive comes from the second byte, which may be the incoming one
    assign drv_cur  = (bw_reg == 4'd1) ? wr_byte[1:0] : cmd_drv_reg;
    assign drv_ext  = {1'b0, drv_cur};

    always_comb begin
        phase_next      = phase_reg;
        bw_next         = bw_reg;
        cmd_op_next     = cmd_op_reg;
        cmd_drv_next    = cmd_drv_reg;
        drive_next      = drive_reg;
        rlen_next       = rlen_reg;
        rpos_next       = rpos_reg;
        reply0_next     = reply0_reg;
        // a pending cylinder fetch lands in the second result byte
        reply1_next     = sense_pend_reg ? (cyl_rd_ok_reg ? cyl_rd_reg : 8'h00)
                                         : reply1_reg;
        sense_pend_next = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = drv_cur;
        mem_wdata       = wr_byte;
        mem_re          = 1'b0;
        rd_byte         = 8'h00;

        if (accept) begin
            unique case (mode)
                fdc_cmd_pkg::MODE_STATUS_RD: begin
                    rd_byte = fdc_cmd_pkg::ST_READY;
                    if (bw_reg != 4'd0 || rpos_reg != 2'd0) begin
                        rd_byte = rd_byte | fdc_cmd_pkg::ST_BUSY;
                    end
                    if (phase_reg == fdc_cmd_pkg::PHASE_RESULT) begin
                        rd_byte = rd_byte | fdc_cmd_pkg::ST_DIO;
                    end
                end
                fdc_cmd_pkg::MODE_DATA_WR: begin
                    if (bw_reg == 4'd0) begin
                        cmd_op_next = wr_byte[3:0];
                    end
                    if (bw_reg == 4'd1) begin
                        cmd_drv_next = wr_byte[1:0];
                    end
                    if (!cmd_done) begin
                        bw_next    = bw_inc;
                        phase_next = fdc_cmd_pkg::PHASE_COMMAND;
                    end else begin
                        bw_next = 4'd0;
                        unique case (op_cur)
                            fdc_cmd_pkg::OP_SPECIFY: begin
                                phase_next = fdc_cmd_pkg::PHASE_IDLE;
                            end
                            fdc_cmd_pkg::OP_WRITE_DATA,
                            fdc_cmd_pkg::OP_READ_DATA: begin
                            end
                            fdc_cmd_pkg::OP_RECALIBRATE: begin
                                drive_next = drv_cur;
                                mem_we     = drv_ext < 3'(fdc_cmd_pkg::DRIVE_COUNT);
                                mem_wdata  = 8'h00;
                                phase_next = fdc_cmd_pkg::PHASE_IDLE;
                            end
                            fdc_cmd_pkg::OP_SEEK: begin
                                // the incoming byte is the new cylinder
                                drive_next = drv_cur;
                                mem_we     = drv_ext < 3'(fdc_cmd_pkg::DRIVE_COUNT);
                                mem_wdata  = wr_byte;
                                phase_next = fdc_cmd_pkg::PHASE_IDLE;
                            end
                            fdc_cmd_pkg::OP_SENSE_INT: begin
                                phase_next = fdc_cmd_pkg::PHASE_RESULT;
                                rlen_next  = 2'd2;
                                rpos_next  = 2'd0;
                                if (drive_reg == 2'd0) begin
                                    reply0_next     = fdc_cmd_pkg::ST0_SEEK_END;
                                    mem_re          = 1'b1;
                                    sense_pend_next = 1'b1;
                                end else begin
                                    reply0_next = fdc_cmd_pkg::ST0_ABNORMAL
                                                | {6'd0, drive_reg};
                                    reply1_next = fdc_cmd_pkg::NO_CYLINDER;
                                end
                            end
                            default: begin
                                phase_next  = fdc_cmd_pkg::PHASE_IDLE;
                                rlen_next   = 2'd0;
                                reply0_next = fdc_cmd_pkg::INVALID_CMD;
                            end
                        endcase
                    end
                end
                fdc_cmd_pkg::MODE_DATA_RD: begin
                    if (phase_reg != fdc_cmd_pkg::PHASE_RESULT) begin
                        rd_byte = fdc_cmd_pkg::ST_READY;
                    end else begin
                        if (rlen_reg > rpos_reg && !rpos_reg[1]) begin
                            rd_byte   = rpos_reg[0] ? reply1_reg : reply0_reg;
                            rpos_next = rpos_reg + 2'd1;
                        end
                        // result exhausted: back to idle
                        if (rlen_reg <= rpos_next) begin
                            phase_next = fdc_cmd_pkg::PHASE_IDLE;
                            rpos_next  = 2'd0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= fdc_cmd_pkg::PHASE_IDLE;
            bw_reg         <= 4'd0;
            drive_reg      <= 2'd0;
            rlen_reg       <= 2'd0;
            rpos_reg       <= 2'd0;
            sense_pend_reg <= 1'b0;
            cyl_valid_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            bw_reg         <= bw_next;
            drive_reg      <= drive_next;
            rlen_reg       <= rlen_next;
            rpos_reg       <= rpos_next;
            sense_pend_reg <= sense_pend_next;
            if (mem_we) begin
                cyl_valid_reg[mem_waddr] <= 1'b1;
            end
            if (accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_op_reg  <= cmd_op_next;
        cmd_drv_reg <= cmd_drv_next;
        reply0_reg  <= reply0_next;
        reply1_reg  <= reply1_next;
        if (accept) begin
            m_tdata_reg <= rd_byte;
        end
    end

    // cylinder memory: one write port, registered read of drive 0
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cyl_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            cyl_rd_reg    <= cyl_mem[0];
            cyl_rd_ok_reg <= cyl_valid_reg[0];
        end
    end

endmodule

@@ tb/floppy_controller_command_phase_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// floppy_controller_command_phase_test - self-checking bench for the command phase
// drives bus accesses as input beats, predicts every read byte from a private
// model of the controller state and checks each output beat against it
// ----------------------------------------------------------------------------
module floppy_controller_command_phase_test;

    // command length by opcode, one nibble per opcode, opcode 0 in the lowest nibble
    localparam logic [63:0] CMD_LEN        = 64'h3199_1291_2992_3991;
    localparam int          CMD_DEPTH      = 10;
    localparam int          PHASE_ITEMS    = 480;   // random accesses per idling phase
    localparam int          LONG_HOLD      = 200;   // receiver hold-off, in cycles
    localparam int          WATCHDOG_LIMIT = 2000;  // cycles with no beat on either side
    localparam int          DRAIN_CYCLES   = 8;

    // ------------------------------------------------------------------------
    // read byte predictor and store of expected read bytes
    // ------------------------------------------------------------------------
    class fdc_read_scoreboard;
        logic [7:0] cmd_buf [CMD_DEPTH];
        logic [3:0] n_written;
        logic [7:0] reply [2];
        logic [1:0] reply_len;
        logic [1:0] reply_pos;
        fdc_cmd_pkg::phase_t phase;
        logic [1:0] drive;
        logic [7:0] cyl [4];
        logic [7:0] expected_reads [$];
        int         mismatches;

        function new();
            foreach (cmd_buf[i]) cmd_buf[i] = 8'h00;
            foreach (cyl[i]) cyl[i] = 8'h00;
            reply[0]   = 8'h00;
            reply[1]   = 8'h00;
            n_written  = 4'd0;
            reply_len  = 2'd0;
            reply_pos  = 2'd0;
            phase      = fdc_cmd_pkg::PHASE_IDLE;
            drive      = 2'd0;
            mismatches = 0;
        endfunction

        // a complete command takes effect
        function void finish_command();
            case (cmd_buf[0][3:0])
                fdc_cmd_pkg::OP_SPECIFY: phase = fdc_cmd_pkg::PHASE_IDLE;
                fdc_cmd_pkg::OP_WRITE_DATA, fdc_cmd_pkg::OP_READ_DATA: ;  // phase kept
                fdc_cmd_pkg::OP_RECALIBRATE: begin
                    drive = cmd_buf[1][1:0];
                    if (int'(drive) < fdc_cmd_pkg::DRIVE_COUNT) cyl[drive] = 8'h00;
                    phase = fdc_cmd_pkg::PHASE_IDLE;
                end
                fdc_cmd_pkg::OP_SENSE_INT: begin
                    phase     = fdc_cmd_pkg::PHASE_RESULT;
                    reply_len = 2'd2;
                    reply_pos = 2'd0;
                    if (drive == 2'd0) begin
                        reply[0] = fdc_cmd_pkg::ST0_SEEK_END | {6'd0, drive};
                        reply[1] = cyl[0];
                    end else begin
                        reply[0] = fdc_cmd_pkg::ST0_ABNORMAL | {6'd0, drive};
                        reply[1] = fdc_cmd_pkg::NO_CYLINDER;
                    end
                end
                fdc_cmd_pkg::OP_SEEK: begin
                    drive = cmd_buf[1][1:0];
                    if (int'(drive) < fdc_cmd_pkg::DRIVE_COUNT) cyl[drive] = cmd_buf[2];
                    phase = fdc_cmd_pkg::PHASE_IDLE;
                end
                default: begin
                    phase     = fdc_cmd_pkg::PHASE_IDLE;
                    reply_len = 2'd0;
                    reply[0]  = fdc_cmd_pkg::INVALID_CMD;
                end
            endcase
        endfunction

        // one bus access: update the state and return the byte read back
        function logic [7:0] predict_read_byte(logic [1:0] mode, logic [7:0] wbyte);
            logic [7:0] r;
            r = 8'h00;
            case (mode)
                fdc_cmd_pkg::MODE_STATUS_RD: begin
                    r = fdc_cmd_pkg::ST_READY;
                    if (n_written != 4'd0 || reply_pos != 2'd0)
                        r = r | fdc_cmd_pkg::ST_BUSY;
                    if (phase == fdc_cmd_pkg::PHASE_RESULT) r = r | fdc_cmd_pkg::ST_DIO;
                end
                fdc_cmd_pkg::MODE_DATA_WR: begin
                    if (int'(n_written) < CMD_DEPTH) cmd_buf[n_written] = wbyte;
                    n_written = n_written + 4'd1;
                    if (CMD_LEN[{cmd_buf[0][3:0], 2'b00} +: 4] <= n_written) begin
                        n_written = 4'd0;
                        finish_command();
                    end else begin
                        phase = fdc_cmd_pkg::PHASE_COMMAND;
                    end
                end
                fdc_cmd_pkg::MODE_DATA_RD: begin
                    if (phase != fdc_cmd_pkg::PHASE_RESULT) begin
                        r = fdc_cmd_pkg::ST_READY;
                    end else begin
                        if (reply_len > reply_pos && reply_pos < 2'd2) begin
                            r = reply[reply_pos[0]];
                            reply_pos = reply_pos + 2'd1;
                        end
                        if (reply_len <= reply_pos) begin
                            phase     = fdc_cmd_pkg::PHASE_IDLE;
                            reply_pos = 2'd0;
                        end
                    end
                end
                default: ;  // unused mode reads 0 and changes nothing
            endcase
            return r;
        endfunction

        function void note_access(logic [1:0] mode, logic [7:0] wbyte);
            expected_reads.push_back(predict_read_byte(mode, wbyte));
        endfunction

        function void check_read(logic [7:0] got);
            logic [7:0] want;
            if (expected_reads.size() == 0) begin
                $display("%0t: read byte %02h with none expected", $time, got);
                mismatches++;
            end else begin
                want = expected_reads.pop_front();
                if (want !== got) begin
                    $display("%0t: read_byte mismatch, expected %02h, got %02h",
                             $time, want, got);
                    mismatches++;
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and the block
    // ------------------------------------------------------------------------
    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [1:0] mode, [9:2] write_byte, [15:10] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] read_byte

    fdc_read_scoreboard board = new();

    int send_idle_pct = 0;   // chance in a hundred that the sender idles a cycle
    int read_stall_pct = 0;  // chance in a hundred that the receiver stalls a cycle
    bit hold_request = 1'b0; // asks the receiver for one long hold-off
    int items_sent = 0;

    floppy_controller_command_phase dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // receiver: random back-pressure, changed on the falling edge
    // ------------------------------------------------------------------------
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                // long hold-off so the output side fills and the input stalls
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end
            m_tready <= (int'($urandom_range(99)) >= read_stall_pct);
        end
    end

    // every accepted output beat is checked against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_read(m_tdata);
    end

    // watchdog: ends the run if neither channel moves a beat for too long
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // sender tasks; called and returning on a falling edge
    // ------------------------------------------------------------------------

    // one access beat, with random idle cycles in front of it; tvalid stays high
    // on return so the caller decides whether the next beat follows at once
    task automatic send_access(input logic [1:0] mode, input logic [7:0] wbyte);
        while (int'($urandom_range(99)) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, wbyte, mode};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_access(mode, wbyte);
        items_sent++;
        @(negedge aclk);
    endtask

    // sender pauses until every expected read byte has come back
    task automatic wait_for_reads();
        s_tvalid <= 1'b0;
        while (board.expected_reads.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // one command with random content, status and data reads mixed in; now and
    // then the command is left half written, and the result phase cut short
    task automatic issue_command();
        logic [3:0] op;
        logic [7:0] b;
        int len;
        int reads;
        case ($urandom_range(9))
            0, 1:    op = fdc_cmd_pkg::OP_SENSE_INT;
            2, 3:    op = fdc_cmd_pkg::OP_SEEK;
            4:       op = fdc_cmd_pkg::OP_RECALIBRATE;
            5:       op = fdc_cmd_pkg::OP_SPECIFY;
            6:       op = ($urandom_range(1) == 1) ? fdc_cmd_pkg::OP_READ_DATA
                                                  : fdc_cmd_pkg::OP_WRITE_DATA;
            default: op = 4'($urandom_range(15));
        endcase
        len = int'(CMD_LEN[{op, 2'b00} +: 4]);
        send_access(fdc_cmd_pkg::MODE_DATA_WR, {4'($urandom_range(15)), op});
        for (int i = 1; i < len; i++) begin
            if ($urandom_range(24) == 0) return;
            case ($urandom_range(7))
                0:       send_access(fdc_cmd_pkg::MODE_STATUS_RD, 8'($urandom_range(255)));
                1:       send_access(fdc_cmd_pkg::MODE_DATA_RD, 8'($urandom_range(255)));
                default: ;
            endcase
            b = 8'($urandom_range(255));
            // drive 0 half the time, since only its cylinder shows in the result
            if (i == 1 && $urandom_range(1) == 1) b[1:0] = 2'b00;
            send_access(fdc_cmd_pkg::MODE_DATA_WR, b);
        end
        if (op == fdc_cmd_pkg::OP_SENSE_INT) begin
            reads = ($urandom_range(7) == 0) ? int'($urandom_range(3)) : 2;
            repeat (reads) begin
                if ($urandom_range(2) == 0)
                    send_access(fdc_cmd_pkg::MODE_STATUS_RD, 8'($urandom_range(255)));
                send_access(fdc_cmd_pkg::MODE_DATA_RD, 8'($urandom_range(255)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 16'd0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: idle reads, the unused mode with all write bits set
        send_access(fdc_cmd_pkg::MODE_STATUS_RD, 8'h00);
        send_access(fdc_cmd_pkg::MODE_DATA_RD, 8'hff);
        send_access(fdc_cmd_pkg::MODE_UNUSED, 8'hff);
        // sense interrupt on drive 0 at reset cylinder, status between the pops
        send_access(fdc_cmd_pkg::MODE_DATA_WR, {4'h0, fdc_cmd_pkg::OP_SENSE_INT});
        send_access(fdc_cmd_pkg::MODE_STATUS_RD, 8'h00);
        send_access(fdc_cmd_pkg::MODE_DATA_RD, 8'h00);
        send_access(fdc_cmd_pkg::MODE_STATUS_RD, 8'h00);
        send_access(fdc_cmd_pkg::MODE_DATA_RD, 8'h00);
        // seek drive 0 to the top cylinder, then read it back
        send_access(fdc_cmd_pkg::MODE_DATA_WR, {4'hf, fdc_cmd_pkg::OP_SEEK});
        send_access(fdc_cmd_pkg::MODE_DATA_WR, 8'hfc);
        send_access(fdc_cmd_pkg::MODE_DATA_WR, 8'hff);
        send_access(fdc_cmd_pkg::MODE_DATA_WR, {4'hf, fdc_cmd_pkg::OP_SENSE_INT});
        send_access(fdc_cmd_pkg::MODE_DATA_RD, 8'h00);
        send_access(fdc_cmd_pkg::MODE_DATA_RD, 8'h00);
        // recalibrate drive 3, whose sense result is abnormal
        send_access(fdc_cmd_pkg::MODE_DATA_WR, {4'h0, fdc_cmd_pkg::OP_RECALIBRATE});
        send_access(fdc_cmd_pkg::MODE_DATA_WR, 8'h03);
        send_access(fdc_cmd_pkg::MODE_DATA_WR, {4'h0, fdc_cmd_pkg::OP_SENSE_INT});
        send_access(fdc_cmd_pkg::MODE_DATA_RD, 8'h00);
        send_access(fdc_cmd_pkg::MODE_DATA_RD, 8'h00);
        // specify with a status read while the command is partly written
        send_access(fdc_cmd_pkg::MODE_DATA_WR, {4'h0, fdc_cmd_pkg::OP_SPECIFY});
        send_access(fdc_cmd_pkg::MODE_STATUS_RD, 8'h00);
        send_access(fdc_cmd_pkg::MODE_DATA_WR, 8'h00);
        send_access(fdc_cmd_pkg::MODE_DATA_WR, 8'hff);
        // unknown one-byte command
        send_access(fdc_cmd_pkg::MODE_DATA_WR, 8'h0e);
        wait_for_reads();

        // random: four idling phases, each ending with the sender paused
        for (int ph = 0; ph < 4; ph++) begin
            int target;
            case (ph)
                0:       begin send_idle_pct = 0;  read_stall_pct = 0;  end
                1:       begin send_idle_pct = 55; read_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  read_stall_pct = 55; end
                default: begin send_idle_pct = 17; read_stall_pct = 17; end
            endcase
            target = items_sent + PHASE_ITEMS;
            if (ph == 0) hold_request = 1'b1;
            while (items_sent < target) begin
                if ($urandom_range(9) == 0)
                    send_access(2'($urandom_range(3)), 8'($urandom_range(255)));
                else
                    issue_command();
            end
            wait_for_reads();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.mismatches == 0 && board.expected_reads.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/fdc_cmd_pkg.sv
src/floppy_controller_command_phase.sv
tb/floppy_controller_command_phase_test.sv
